@@ sv/sbps_pkg.sv @@
package sbps_pkg;

    localparam int CLK_W      = 28;
    localparam int REQ_W      = 27;
    localparam int RATE_W     = 27;
    localparam int PRE_CODE_W = 2;
    localparam int DIV_CODE_W = 4;
    localparam int NUM_PRE    = 4;
    localparam int PRE_W      = 3;
    localparam int CNT_W      = 5;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam int DIVIDER_STEPS_DEF = 14;

    localparam logic [CLK_W-1:0] SRC_CLK_RESET = CLK_W'(50000000);

    // Register index taken from paddr[2]; only the source clock exists.
    localparam logic REG_SOURCE_CLOCK = 1'b0;

    localparam logic [PRE_W-1:0] PRESCALERS [NUM_PRE] = '{3'd2, 3'd3, 3'd5, 3'd7};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MERGE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  load;
        logic                  div_step;
        logic                  scan_step;
        logic [DIV_CODE_W-1:0] d;
    } t_lane_ctl;

    typedef struct packed {
        logic                  hit;
        logic [DIV_CODE_W-1:0] d;
        logic [RATE_W-1:0]     rate;
    } t_lane_stat;

endpackage

@@ sv/spi_baud_prescaler_search_core.sv @@
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_requested_rate_hz
// result    out        o_valid / i_ready   codes, o_actual_rate_hz, flags
// config    in         APB psel/penable    source clock at byte address 0
//
// Four bit-serial dividers (one per prescaler) divide the source clock, one clock bit at a time.
// Each lane then shifts its quotient once per divider code to find its first rate at or
// below the request, and a merge of up to four steps picks the answer in prescaler order.
// Reset is synchronous, active low, and loads the source clock with 50 MHz.
// A new request is taken while a finished result still waits in the output register.
module spi_baud_prescaler_search_core #(
    parameter int DIVIDER_STEPS = sbps_pkg::DIVIDER_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sbps_pkg::REQ_W-1:0]        i_requested_rate_hz,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sbps_pkg::PRE_CODE_W-1:0]   o_prescale_code,
    output logic [sbps_pkg::DIV_CODE_W-1:0]   o_divider_code,
    output logic [sbps_pkg::RATE_W-1:0]       o_actual_rate_hz,
    output logic                              o_exact_match,
    output logic                              o_found,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbps_pkg::ADDR_W-1:0]       paddr,
    input  logic [sbps_pkg::DATA_W-1:0]       pwdata,
    output logic [sbps_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import sbps_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(CLK_W - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST  = CNT_W'(DIVIDER_STEPS - 1);
    localparam logic [CNT_W-1:0] MERGE_LAST = CNT_W'(NUM_PRE - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [CLK_W-1:0] r_source_clock_hz;
    logic [REQ_W-1:0] r_req;

    logic                  r_have, r_exact;
    logic [PRE_CODE_W-1:0] r_sel_p;
    logic [DIV_CODE_W-1:0] r_sel_d;
    logic [RATE_W-1:0]     r_best;

    logic                  r_out_valid;
    logic [PRE_CODE_W-1:0] r_out_p;
    logic [DIV_CODE_W-1:0] r_out_d;
    logic [RATE_W-1:0]     r_out_rate;
    logic                  r_out_exact;
    logic                  r_out_found;

    t_lane_ctl  w_ctl;
    t_lane_stat w_stat [NUM_PRE];
    t_lane_stat w_cur;

    logic w_accept;
    logic w_out_load;
    logic w_cur_exact;
    logic w_cur_better;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == ST_IDLE);

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_clock_hz <= SRC_CLK_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SOURCE_CLOCK)) begin
            r_source_clock_hz <= pwdata[CLK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SOURCE_CLOCK) begin
            prdata = {{(DATA_W - CLK_W){1'b0}}, r_source_clock_hz};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_requested_rate_hz;
        end
    end

    // Search lanes, one per prescaler.
    for (genvar g = 0; g < NUM_PRE; g++) begin : g_lane
        sbps_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_clock_hz (r_source_clock_hz),
            .i_divisor  (PRESCALERS[g]),
            .i_req      (r_req),
            .o_stat     (w_stat[g])
        );
    end

    assign w_cur        = w_stat[r_cnt[PRE_CODE_W-1:0]];
    assign w_cur_exact  = w_cur.hit && ({1'b0, w_cur.rate} == {1'b0, r_req});
    assign w_cur_better = w_cur.hit && (w_cur.rate > r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        w_ctl.load      = 1'b0;
        w_ctl.div_step  = 1'b0;
        w_ctl.scan_step = 1'b0;
        w_ctl.d         = r_cnt[DIV_CODE_W-1:0];
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                w_ctl.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SCAN: begin
                w_ctl.scan_step = 1'b1;
                if (r_cnt == SCAN_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_MERGE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MERGE: begin
                // An exact rate ends the search; later prescalers are not looked at.
                if (w_cur_exact || (r_cnt == MERGE_LAST)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_exact <= 1'b0;
        end else if (w_ctl.load) begin
            r_have  <= 1'b0;
            r_exact <= 1'b0;
        end else if ((r_state == ST_MERGE) && (w_cur_exact || w_cur_better)) begin
            r_have  <= 1'b1;
            r_exact <= w_cur_exact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_sel_p <= '0;
            r_sel_d <= '0;
            r_best  <= '0;
        end else if ((r_state == ST_MERGE) && (w_cur_exact || w_cur_better)) begin
            r_sel_p <= r_cnt[PRE_CODE_W-1:0];
            r_sel_d <= w_cur.d;
            r_best  <= w_cur.rate;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_p     <= r_sel_p;
            r_out_d     <= r_sel_d;
            r_out_rate  <= r_best;
            r_out_exact <= r_exact;
            r_out_found <= r_have;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_prescale_code  = r_out_p;
    assign o_divider_code   = r_out_d;
    assign o_actual_rate_hz = r_out_rate;
    assign o_exact_match    = r_out_exact;
    assign o_found          = r_out_found;

endmodule

@@ sv/sbps_lane.sv @@
module sbps_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbps_pkg::t_lane_ctl           i_ctl,
    input  logic [sbps_pkg::CLK_W-1:0]    i_clock_hz,
    input  logic [sbps_pkg::PRE_W-1:0]    i_divisor,
    input  logic [sbps_pkg::REQ_W-1:0]    i_req,
    output sbps_pkg::t_lane_stat          o_stat
);
    import sbps_pkg::*;

    logic [CLK_W-1:0]      r_work;
    logic [PRE_W-1:0]      r_rem;
    logic                  r_hit;
    logic [DIV_CODE_W-1:0] r_d;
    logic [RATE_W-1:0]     r_rate;

    logic [PRE_W:0]        w_trial;
    logic                  w_ge;
    logic [PRE_W:0]        w_diff;
    logic [RATE_W-1:0]     w_cand;

    // Restoring division, one dividend bit per cycle: the dividend leaves at
    // the top of r_work while quotient bits enter at the bottom.
    assign w_trial = {r_rem, r_work[CLK_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    // During the scan r_work holds quotient >> d, so the rate is one more shift.
    assign w_cand  = r_work[CLK_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.load) begin
            r_hit <= 1'b0;
        end else if (i_ctl.scan_step && !r_hit && (w_cand <= i_req)) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_work <= i_clock_hz;
            r_rem  <= '0;
        end else if (i_ctl.div_step) begin
            r_work <= {r_work[CLK_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[PRE_W-1:0] : w_trial[PRE_W-1:0];
        end else if (i_ctl.scan_step) begin
            r_work <= {1'b0, r_work[CLK_W-1:1]};
            if (!r_hit && (w_cand <= i_req)) begin
                r_d    <= i_ctl.d;
                r_rate <= w_cand;
            end
        end
    end

    assign o_stat.hit  = r_hit;
    assign o_stat.d    = r_d;
    assign o_stat.rate = r_rate;

endmodule

@@ sv/sbps_checker.sv @@
module sbps_checker #(
    parameter int DIVIDER_STEPS = sbps_pkg::DIVIDER_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_ready,
    input  logic [sbps_pkg::REQ_W-1:0]        i_requested_rate_hz,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic [sbps_pkg::PRE_CODE_W-1:0]   o_prescale_code,
    input  logic [sbps_pkg::DIV_CODE_W-1:0]   o_divider_code,
    input  logic [sbps_pkg::RATE_W-1:0]       o_actual_rate_hz,
    input  logic                              o_exact_match,
    input  logic                              o_found,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbps_pkg::ADDR_W-1:0]       paddr,
    input  logic [sbps_pkg::DATA_W-1:0]       pwdata,
    input  logic [sbps_pkg::DATA_W-1:0]       prdata,
    input  logic                              pready
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_actual_rate_hz)
                                   && $stable(o_found) && $stable(o_divider_code)))
        else $error("result changed while stalled");

    // A transfer starts the search, so the block is busy right after it.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while a search runs");

    a_exact_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exact_match) |-> o_found)
        else $error("exact match without found");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> ((o_actual_rate_hz == '0) && (o_prescale_code == '0)
                                   && (o_divider_code == '0) && !o_exact_match))
        else $error("not-found result carries nonzero fields");

    a_divider_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_divider_code) < 32'(DIVIDER_STEPS)))
        else $error("divider code out of range");

endmodule

bind spi_baud_prescaler_search_core sbps_checker #(
    .DIVIDER_STEPS(DIVIDER_STEPS)
) u_sbps_checker (.*);

@@ verif/spi_baud_prescaler_search_core_test.sv @@
`timescale 1ns / 1ps

module spi_baud_prescaler_search_core_test;

    import sbps_pkg::*;

    localparam int DIV_STEPS = 14;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [ADDR_W-1:0] SRC_CLK_ADDR = '0;
    localparam logic [CLK_W-1:0] CLK_HZ_MAX = '1;
    localparam longint unsigned PRESCALE_VAL [4] = '{64'd2, 64'd3, 64'd5, 64'd7};

    typedef struct packed {
        logic [PRE_CODE_W-1:0] pre;
        logic [DIV_CODE_W-1:0] div;
        logic [RATE_W-1:0]     rate;
        logic                  exact;
        logic                  found;
    } baud_sel_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [REQ_W-1:0]      i_requested_rate_hz = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PRE_CODE_W-1:0] o_prescale_code;
    logic [DIV_CODE_W-1:0] o_divider_code;
    logic [RATE_W-1:0]     o_actual_rate_hz;
    logic                  o_exact_match;
    logic                  o_found;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    logic [REQ_W-1:0] rate_req_q [$];
    baud_sel_t        baud_expect_q [$];
    logic [CLK_W-1:0] src_clk_model = SRC_CLK_RESET;

    int n_requests = 0;
    int n_results = 0;
    int n_exact = 0;
    int n_missing = 0;
    int n_clk_writes = 0;
    int n_errors = 0;
    int send_burst = 1;
    int send_gap = 0;
    int ready_mode = 0;
    int ready_tick = 0;
    int idle_cycles = 0;
    baud_sel_t want_sel;
    baud_sel_t got_sel;

    spi_baud_prescaler_search_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_requested_rate_hz (i_requested_rate_hz),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_prescale_code     (o_prescale_code),
        .o_divider_code      (o_divider_code),
        .o_actual_rate_hz    (o_actual_rate_hz),
        .o_exact_match       (o_exact_match),
        .o_found             (o_found),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Walk the prescalers in order; a divider that hits the request ends the walk, and within
    // one prescaler the first divider that improves on the best rate below it ends that prescaler.
    function automatic baud_sel_t search_baud(input logic [CLK_W-1:0] clk_hz,
                                              input logic [REQ_W-1:0] req);
        baud_sel_t sel;
        longint unsigned rate;
        longint unsigned best;
        bit done;
        sel = '0;
        best = 0;
        done = 1'b0;
        for (int p = 0; p < 4 && !done; p++) begin
            for (int d = 0; d < DIV_STEPS; d++) begin
                rate = longint'(clk_hz) / (PRESCALE_VAL[p] * (64'd2 << d));
                if (rate == longint'(req)) begin
                    sel = '{PRE_CODE_W'(p), DIV_CODE_W'(d), RATE_W'(rate), 1'b1, 1'b1};
                    done = 1'b1;
                    break;
                end
                if (rate > best && rate < longint'(req)) begin
                    best = rate;
                    sel = '{PRE_CODE_W'(p), DIV_CODE_W'(d), RATE_W'(rate), 1'b0, 1'b1};
                    break;
                end
            end
        end
        return sel;
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input logic [CLK_W-1:0] clk_hz);
        longint unsigned base;
        longint signed val;
        int kind;
        kind = $urandom_range(0, 9);
        base = longint'(clk_hz) / (PRESCALE_VAL[$urandom_range(0, 3)] *
                                   (64'd2 << $urandom_range(0, DIV_STEPS - 1)));
        case (kind)
            0, 1, 2, 3: val = longint'(base) + $urandom_range(0, 2) - 1;
            4, 5: val = $urandom_range(0, (clk_hz >> 2) + 16);
            6: val = $urandom_range(0, 1000);
            7: val = $urandom & {REQ_W{1'b1}};
            8: val = longint'(base) + $urandom_range(0, 64) - 32;
            default: val = $urandom_range(1, 100000000);
        endcase
        if (val < 0) begin
            val = 0;
        end
        return REQ_W'(val);
    endfunction

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic write_src_clock(input logic [CLK_W-1:0] clk_hz);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SRC_CLK_ADDR;
        pwdata <= DATA_W'(clk_hz);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        src_clk_model = clk_hz;
        n_clk_writes++;
        // Read the register back to confirm the write landed.
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        report_field("source clock readback", clk_hz, prdata[CLK_W-1:0]);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rate_req_q.size() > 0 || baud_expect_q.size() > 0 || i_valid) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CLK_W-1:0] clk_hz, input int n_items);
        wait_drained();
        write_src_clock(clk_hz);
        rate_req_q.push_back('0);
        rate_req_q.push_back(REQ_W'(1));
        rate_req_q.push_back({REQ_W{1'b1}});
        for (int i = 0; i < n_items; i++) begin
            rate_req_q.push_back(pick_request(clk_hz));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset clock of 50 MHz: boundaries and exact hits of several prescalers.
        rate_req_q = '{27'd0, 27'd1, {REQ_W{1'b1}}, 27'd100000000, 27'd12500000,
                       27'd12500001, 27'd12499999, 27'd8333333, 27'd8333334,
                       27'd5000000, 27'd3571428, 27'd435, 27'd436, 27'd434, 27'd217,
                       27'd216, 27'd218, 27'd762, 27'd1000, 27'd9000000};
        for (int i = 0; i < 30; i++) begin
            rate_req_q.push_back(pick_request(SRC_CLK_RESET));
        end

        // A stopped clock gives only zero rates; a 1 Hz clock likewise.
        run_phase('0, 20);
        run_phase(CLK_W'(1), 20);
        run_phase(CLK_W'(200000000), 60);
        run_phase(CLK_HZ_MAX, 60);
        run_phase(CLK_W'($urandom_range(2, 100000)), 60);
        run_phase(SRC_CLK_RESET, 30);
        for (int i = 0; i < 4; i++) begin
            run_phase(CLK_W'($urandom_range(1, 200000000)), 60);
        end

        wait_drained();
        $display("Checked %0d results for %0d requests over %0d source clock writes.",
                 n_results, n_requests, n_clk_writes);
        $display("Exact matches: %0d, no rate at or below the request: %0d, errors: %0d.",
                 n_exact, n_missing, n_errors);
        if (n_errors == 0 && baud_expect_q.size() == 0) begin
            $display("spi_baud_prescaler_search_core_test: PASS");
        end else begin
            $display("spi_baud_prescaler_search_core_test: FAIL");
        end
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                baud_expect_q.push_back(search_baud(src_clk_model, i_requested_rate_hz));
                n_requests++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (rate_req_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_requested_rate_hz <= rate_req_q.pop_front();
                    if (send_burst > 1) begin
                        send_burst--;
                    end else begin
                        send_burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
                        send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                got_sel = '{o_prescale_code, o_divider_code, o_actual_rate_hz,
                            o_exact_match, o_found};
                if (baud_expect_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, got_sel);
                    n_errors++;
                end else begin
                    want_sel = baud_expect_q.pop_front();
                    n_exact += want_sel.exact;
                    n_missing += !want_sel.found;
                    report_field("prescale_code", want_sel.pre, got_sel.pre);
                    report_field("divider_code", want_sel.div, got_sel.div);
                    report_field("actual_rate_hz", want_sel.rate, got_sel.rate);
                    report_field("exact_match", want_sel.exact, got_sel.exact);
                    report_field("found", want_sel.found, got_sel.found);
                end
            end
            ready_tick++;
            if (ready_tick % 48 == 0) begin
                ready_mode = $urandom_range(0, 3);
            end
            case (ready_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= $urandom_range(0, 1);
                2: i_ready <= (ready_tick % 6 == 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("spi_baud_prescaler_search_core_test: FAIL");
            $finish;
        end
    end

endmodule
